// ----- src/pmx_mss_pkg.sv -----
// Package for the PMX model section scanner: item types, scan phases, status codes.
// Used by pmx_mss_core and pmx_model_section_scanner; depends on nothing.
`default_nettype none
package pmx_mss_pkg;

  localparam int unsigned PositionWidthDefault = 32;
  localparam int unsigned SkipWidth = 34;
  localparam logic [31:0] SignatureWord = 32'h2058_4d50;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        text_is_utf8;
    logic [2:0]  extra_vec4_count;
    logic [2:0]  bone_index_bytes;
    logic [2:0]  vertex_index_bytes;
    logic [2:0]  texture_index_bytes;
    logic [31:0] vertex_section_start;
    logic [31:0] surface_section_start;
    logic [31:0] material_section_start;
    logic [30:0] material_total;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_SIGNATURE  = 4'd1,
    ST_ENCODING   = 4'd2,
    ST_TEXT_LEN   = 4'd3,
    ST_SIZES      = 4'd4,
    ST_NEG_COUNT  = 4'd5,
    ST_DEFORM     = 4'd6,
    ST_TRUNCATED  = 4'd7,
    ST_TOO_LARGE  = 4'd8
  } status_e;

  typedef enum logic [4:0] {
    PH_IDLE, PH_SIG, PH_HEADSKIP, PH_GLOBALS, PH_TXT_LEN, PH_TXT_SKIP,
    PH_VCOUNT, PH_VFIXED, PH_VDEFORM, PH_VTAIL, PH_SCOUNT, PH_SSKIP,
    PH_TCOUNT, PH_MCOUNT
  } phase_e;

endpackage
`default_nettype wire

// ----- src/pmx_mss_core.sv -----
// Scan state and one-byte step logic of the PMX model section scanner.
// Depends on pmx_mss_pkg.
`default_nettype none
module pmx_mss_core #(
  parameter int unsigned PositionWidth = pmx_mss_pkg::PositionWidthDefault
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    step_i,
  input  pmx_mss_pkg::in_item_t  item_i,
  output logic                   res_valid_o,
  output pmx_mss_pkg::out_item_t res_o
);

  localparam int unsigned PosW = PositionWidth + 1;
  localparam int unsigned ExtW = (PosW > 32) ? PosW : 32;
  localparam int unsigned SkW  = pmx_mss_pkg::SkipWidth;

  pmx_mss_pkg::phase_e phase_q, phase_d, phase_c;
  logic [PosW-1:0] pos_q, pos_d, pos_c;
  logic [SkW-1:0]  skip_q, skip_d, skip_c;
  logic [23:0]     word_q, word_d, word_c;
  logic [2:0]      cnt_q, cnt_d, cnt_c;
  logic [30:0]     rec_q, rec_d, rec_c;
  logic [2:0]      tfl_q, tfl_d, tfl_c;
  logic            g0_q, g0_d;
  logic [7:0]      g1_q, g1_d, g2_q, g2_d, g3_q, g3_d, g5_q, g5_d;
  logic [31:0]     vs_q, vs_d, ss_q, ss_d, ms_q, ms_d;

  logic [7:0]      b;
  logic [31:0]     w;
  logic            word_end, has_st, txt_done, active;
  pmx_mss_pkg::status_e st;
  logic [ExtW-1:0] next_pos_ext;
  logic [31:0]     start32;
  logic [SkW-1:0]  bb;

  always_comb begin
    b = item_i.data_byte;
    if (item_i.start_of_file) begin
      phase_c = pmx_mss_pkg::PH_SIG;
      pos_c   = '0;
      skip_c  = '0;
      word_c  = '0;
      cnt_c   = '0;
      rec_c   = '0;
      tfl_c   = '0;
    end else begin
      phase_c = phase_q;
      pos_c   = pos_q;
      skip_c  = skip_q;
      word_c  = word_q;
      cnt_c   = cnt_q;
      rec_c   = rec_q;
      tfl_c   = tfl_q;
    end
    phase_d = phase_c;
    pos_d   = pos_c;
    skip_d  = skip_c;
    word_d  = word_c;
    cnt_d   = cnt_c;
    rec_d   = rec_c;
    tfl_d   = tfl_c;
    g0_d = g0_q; g1_d = g1_q; g2_d = g2_q; g3_d = g3_q; g5_d = g5_q;
    vs_d = vs_q; ss_d = ss_q; ms_d = ms_q;
    has_st   = 1'b0;
    st       = pmx_mss_pkg::ST_OK;
    txt_done = 1'b0;
    w        = {b, word_c};
    word_end = (cnt_c == 3'd3);
    bb       = SkW'(g5_q);
    next_pos_ext = ExtW'(pos_c) + ExtW'(1);
    start32  = next_pos_ext[31:0];
    active   = (phase_c != pmx_mss_pkg::PH_IDLE);

    // Word collection shared by the signature phase and all count and length phases.
    if (phase_c == pmx_mss_pkg::PH_SIG || phase_c == pmx_mss_pkg::PH_TXT_LEN ||
        phase_c == pmx_mss_pkg::PH_VCOUNT || phase_c == pmx_mss_pkg::PH_SCOUNT ||
        phase_c == pmx_mss_pkg::PH_TCOUNT || phase_c == pmx_mss_pkg::PH_MCOUNT) begin
      if (word_end) begin
        cnt_d = '0;
      end else begin
        cnt_d = cnt_c + 3'd1;
        case (cnt_c[1:0])
          2'd0:    word_d[7:0]   = b;
          2'd1:    word_d[15:8]  = b;
          default: word_d[23:16] = b;
        endcase
      end
    end

    if (!active) begin
      // Idle: the byte is ignored.
    end else if (pos_c[PosW-1]) begin
      has_st = 1'b1;
      st     = pmx_mss_pkg::ST_TOO_LARGE;
    end else begin
      case (phase_c)
        pmx_mss_pkg::PH_SIG: begin
          if (word_end) begin
            if (w != pmx_mss_pkg::SignatureWord) begin
              has_st = 1'b1;
              st     = pmx_mss_pkg::ST_SIGNATURE;
            end else begin
              phase_d = pmx_mss_pkg::PH_HEADSKIP;
              skip_d  = SkW'(5);
            end
          end
        end
        pmx_mss_pkg::PH_HEADSKIP: begin
          skip_d = skip_c - SkW'(1);
          if (skip_c == SkW'(1)) begin
            phase_d = pmx_mss_pkg::PH_GLOBALS;
            cnt_d   = '0;
          end
        end
        pmx_mss_pkg::PH_GLOBALS: begin
          case (cnt_c)
            3'd0:    g0_d = b[0];
            3'd1:    g1_d = b;
            3'd2:    g2_d = b;
            3'd3:    g3_d = b;
            3'd5:    g5_d = b;
            default: ;
          endcase
          if (cnt_c == 3'd0 && b > 8'd1) begin
            // Remembered as an encoding error below once all globals are in.
            g0_d = 1'b1;
          end
          if (cnt_c != 3'd7) begin
            cnt_d = cnt_c + 3'd1;
          end else if (enc_bad_q) begin
            has_st = 1'b1;
            st     = pmx_mss_pkg::ST_ENCODING;
          end else begin
            tfl_d   = 3'd4;
            phase_d = pmx_mss_pkg::PH_TXT_LEN;
            word_d  = '0;
            cnt_d   = '0;
          end
        end
        pmx_mss_pkg::PH_TXT_LEN: begin
          if (word_end) begin
            if (w[31]) begin
              has_st = 1'b1;
              st     = pmx_mss_pkg::ST_TEXT_LEN;
            end else if (w == 32'd0) begin
              txt_done = 1'b1;
            end else if (!g0_q && w[0]) begin
              has_st = 1'b1;
              st     = pmx_mss_pkg::ST_TEXT_LEN;
            end else begin
              phase_d = pmx_mss_pkg::PH_TXT_SKIP;
              skip_d  = SkW'(w);
            end
          end
        end
        pmx_mss_pkg::PH_TXT_SKIP: begin
          skip_d = skip_c - SkW'(1);
          if (skip_c == SkW'(1)) txt_done = 1'b1;
        end
        pmx_mss_pkg::PH_VCOUNT: begin
          if (word_end) begin
            if (w[31]) begin
              has_st = 1'b1;
              st     = pmx_mss_pkg::ST_NEG_COUNT;
            end else if (w == 32'd0) begin
              ss_d    = start32;
              phase_d = pmx_mss_pkg::PH_SCOUNT;
              word_d  = '0;
              cnt_d   = '0;
            end else begin
              rec_d   = w[30:0];
              phase_d = pmx_mss_pkg::PH_VFIXED;
              skip_d  = SkW'(32) + (SkW'(g1_q) << 4);
            end
          end
        end
        pmx_mss_pkg::PH_VFIXED: begin
          skip_d = skip_c - SkW'(1);
          if (skip_c == SkW'(1)) phase_d = pmx_mss_pkg::PH_VDEFORM;
        end
        pmx_mss_pkg::PH_VDEFORM: begin
          phase_d = pmx_mss_pkg::PH_VTAIL;
          case (b)
            8'd0:    skip_d = bb + SkW'(4);
            8'd1:    skip_d = (bb << 1) + SkW'(8);
            8'd2:    skip_d = (bb << 2) + SkW'(20);
            8'd3:    skip_d = (bb << 1) + SkW'(44);
            8'd4:    skip_d = (bb << 2) + SkW'(20);
            default: begin
              has_st = 1'b1;
              st     = pmx_mss_pkg::ST_DEFORM;
            end
          endcase
        end
        pmx_mss_pkg::PH_VTAIL: begin
          skip_d = skip_c - SkW'(1);
          if (skip_c == SkW'(1)) begin
            rec_d = rec_c - 31'd1;
            if (rec_c != 31'd1) begin
              phase_d = pmx_mss_pkg::PH_VFIXED;
              skip_d  = SkW'(32) + (SkW'(g1_q) << 4);
            end else begin
              ss_d    = start32;
              phase_d = pmx_mss_pkg::PH_SCOUNT;
              word_d  = '0;
              cnt_d   = '0;
            end
          end
        end
        pmx_mss_pkg::PH_SCOUNT: begin
          if (word_end) begin
            if (w[31]) begin
              has_st = 1'b1;
              st     = pmx_mss_pkg::ST_NEG_COUNT;
            end else begin
              case (g2_q)
                8'd1:    skip_d = SkW'(w);
                8'd2:    skip_d = SkW'(w) << 1;
                default: skip_d = SkW'(w) << 2;
              endcase
              if (w == 32'd0) begin
                phase_d = pmx_mss_pkg::PH_TCOUNT;
                word_d  = '0;
                cnt_d   = '0;
              end else begin
                phase_d = pmx_mss_pkg::PH_SSKIP;
              end
            end
          end
        end
        pmx_mss_pkg::PH_SSKIP: begin
          skip_d = skip_c - SkW'(1);
          if (skip_c == SkW'(1)) begin
            phase_d = pmx_mss_pkg::PH_TCOUNT;
            word_d  = '0;
            cnt_d   = '0;
          end
        end
        pmx_mss_pkg::PH_TCOUNT: begin
          if (word_end) begin
            if (w[31]) begin
              has_st = 1'b1;
              st     = pmx_mss_pkg::ST_NEG_COUNT;
            end else if (w == 32'd0) begin
              ms_d    = start32;
              phase_d = pmx_mss_pkg::PH_MCOUNT;
              word_d  = '0;
              cnt_d   = '0;
            end else begin
              rec_d   = w[30:0];
              tfl_d   = '0;
              phase_d = pmx_mss_pkg::PH_TXT_LEN;
              word_d  = '0;
              cnt_d   = '0;
            end
          end
        end
        pmx_mss_pkg::PH_MCOUNT: begin
          if (word_end) begin
            has_st = 1'b1;
            st     = w[31] ? pmx_mss_pkg::ST_NEG_COUNT : pmx_mss_pkg::ST_OK;
          end
        end
        default: ;
      endcase
    end

    // A header text or a texture path has been fully consumed.
    if (txt_done) begin
      word_d = '0;
      cnt_d  = '0;
      if (tfl_c != 3'd0) begin
        tfl_d = tfl_c - 3'd1;
        if (tfl_c != 3'd1) begin
          phase_d = pmx_mss_pkg::PH_TXT_LEN;
        end else if (g1_q > 8'd4 || !size_ok(g5_q) || !size_ok(g2_q) ||
                     !size_ok(g3_q)) begin
          has_st = 1'b1;
          st     = pmx_mss_pkg::ST_SIZES;
        end else begin
          vs_d    = start32;
          phase_d = pmx_mss_pkg::PH_VCOUNT;
        end
      end else begin
        rec_d = rec_c - 31'd1;
        if (rec_c != 31'd1) begin
          phase_d = pmx_mss_pkg::PH_TXT_LEN;
        end else begin
          ms_d    = start32;
          phase_d = pmx_mss_pkg::PH_MCOUNT;
        end
      end
    end

    if (active) begin
      pos_d = pos_c[PosW-1] ? pos_c : pos_c + PosW'(1);
      if (!has_st && item_i.end_of_stream) begin
        has_st = 1'b1;
        st     = pmx_mss_pkg::ST_TRUNCATED;
      end
    end
    if (has_st) phase_d = pmx_mss_pkg::PH_IDLE;
  end

  function automatic logic size_ok(input logic [7:0] v);
    size_ok = (v == 8'd1) || (v == 8'd2) || (v == 8'd4);
  endfunction

  // Encoding byte above one, kept apart from the single stored UTF-8 bit.
  logic enc_bad_q, enc_bad_d;
  always_comb begin
    enc_bad_d = enc_bad_q;
    if (phase_c == pmx_mss_pkg::PH_GLOBALS && cnt_c == 3'd0) enc_bad_d = (b > 8'd1);
  end

  always_comb begin
    res_valid_o = step_i && has_st;
    res_o       = '0;
    res_o.status = st;
    if (st == pmx_mss_pkg::ST_OK) begin
      res_o.text_is_utf8           = g0_q;
      res_o.extra_vec4_count       = g1_q[2:0];
      res_o.bone_index_bytes       = g5_q[2:0];
      res_o.vertex_index_bytes     = g2_q[2:0];
      res_o.texture_index_bytes    = g3_q[2:0];
      res_o.vertex_section_start   = vs_q;
      res_o.surface_section_start  = ss_q;
      res_o.material_section_start = ms_q;
      res_o.material_total         = w[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pmx_mss_pkg::PH_IDLE;
      pos_q   <= '0;
      skip_q  <= '0;
      word_q  <= '0;
      cnt_q   <= '0;
      rec_q   <= '0;
      tfl_q   <= '0;
      vs_q    <= '0;
      ss_q    <= '0;
      ms_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      skip_q  <= skip_d;
      word_q  <= word_d;
      cnt_q   <= cnt_d;
      rec_q   <= rec_d;
      tfl_q   <= tfl_d;
      vs_q    <= vs_d;
      ss_q    <= ss_d;
      ms_q    <= ms_d;
    end
  end

  // Global setting bytes are undefined until written and carry no reset.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      g0_q      <= g0_d;
      g1_q      <= g1_d;
      g2_q      <= g2_d;
      g3_q      <= g3_d;
      g5_q      <= g5_d;
      enc_bad_q <= enc_bad_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/pmx_model_section_scanner.sv -----
// Top level of the PMX model section scanner: input register, scan core, result register.
// Depends on pmx_mss_pkg and pmx_mss_core.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+---------------------------
//   input   | in_valid_i / in_ready_o   | in_data_i  (in_item_t)
//   result  | out_valid_o / out_ready_i | out_data_o (out_item_t)
//
// Each byte item is taken into the input register and stepped through the
// scan core in the next cycle unless a result stalls, so one item per cycle
// is sustained while results drain; a result is registered as its byte steps.
// The core only steps when the result register is empty or being drained,
// so a stalled result holds the input register and then in_ready_o.
// Reset clears the scan state to idle; the scanner waits for a byte with
// start_of_file set. The global setting bytes have no reset.
`default_nettype none
module pmx_model_section_scanner #(
  parameter int unsigned PositionWidth = pmx_mss_pkg::PositionWidthDefault
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  pmx_mss_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output pmx_mss_pkg::out_item_t out_data_o
);

  logic                   in_valid_q;
  pmx_mss_pkg::in_item_t  in_q;
  logic                   out_valid_q;
  pmx_mss_pkg::out_item_t out_q;
  logic                   step;
  logic                   res_valid;
  pmx_mss_pkg::out_item_t res;

  // A held byte steps whenever its result, if any, has a free slot.
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  pmx_mss_core #(
    .PositionWidth(PositionWidth)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_data_i;
    if (res_valid) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An error result carries no material count.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != pmx_mss_pkg::ST_OK) |-> (out_q.material_total == 31'd0))
    else $error("error result with nonzero material count");

  // The core never steps while a result waits unread.
  a_no_step_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !step)
    else $error("core stepped over a stalled result");

  // A held byte that did not step stays held.
  a_hold_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |=> in_valid_q)
    else $error("held byte lost");

endmodule
`default_nettype wire
